@@ rtl/srpd_pkg.sv @@
// ----------------------------------------------------------------------------
// srpd_pkg: shared types and constants
// Request and register codes, pipeline step counts and word layouts used by
// the soft radial point displacement block.
// ----------------------------------------------------------------------------
package srpd_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [0:0] {
    CFG_BRUSH_X = 1'b0,
    CFG_BRUSH_Y = 1'b1
  } cfg_reg_e;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned RADIUS_W = 32;
  localparam int unsigned SOFT_W   = 17;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned FRAC_W   = 16;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h1_0000;

  // square root: one result bit per step, 32 steps
  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned SQRT_PER_STAGE = 2;
  localparam int unsigned SQRT_STAGES    = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  // restoring divide: 17 quotient bits (the falloff fraction is never above 1.0 in Q1.16)
  localparam int unsigned DIV_STEPS     = 17;
  localparam int unsigned DIV_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // front regs (3), sqrt, pre-divide reg, divide, mid reg, divide, weight reg
  localparam int unsigned CELL_LAT = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1 + DIV_STAGES + 1;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [RADIUS_W-1:0] r;
    logic [SOFT_W-1:0]   s;
  } entry_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] r;
    logic [SOFT_W-1:0]   s;
    logic                kill;
  } sq_side_t;

  typedef struct packed {
    logic               move;
    logic               full;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } pay_t;

  // p + floor(disp * w / 65536) with m = |disp| * w, saturated to 32 bits
  function automatic logic [COORD_W-1:0] move_axis(logic [COORD_W-1:0] p, logic neg,
                                                   logic [48:0] m);
    logic [49:0] mr;
    logic [33:0] mag;
    logic [35:0] pe;
    logic [35:0] qe;
    logic [35:0] sum;
    logic [COORD_W-1:0] res;
    mr  = neg ? ({1'b0, m} + 50'd65535) : {1'b0, m};
    mag = mr[49:16];
    pe  = {{4{p[31]}}, p};
    qe  = {2'b00, mag};
    if (neg) begin
      qe = 36'd0 - qe;
    end
    sum = pe + qe;
    if (sum[35:31] != {5{sum[35]}}) begin
      res = sum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = sum[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/srpd_isqrt.sv @@
// ----------------------------------------------------------------------------
// srpd_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, two result bits per register stage,
// with a sideband word that travels alongside.
// ----------------------------------------------------------------------------
module srpd_isqrt #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [63:0]   n_i,
  input  logic [SW-1:0] side_i,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned STG = srpd_pkg::SQRT_STAGES;
  localparam int unsigned PER = srpd_pkg::SQRT_PER_STAGE;

  logic [63:0]   n_s    [STG+1];
  logic [33:0]   rem_s  [STG+1];
  logic [31:0]   root_s [STG+1];
  logic [SW-1:0] side_s [STG+1];

  assign n_s[0]    = n_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar g = 0; g < STG; g++) begin : g_stage
    logic [63:0]   n_d, n_q;
    logic [33:0]   rem_d, rem_q;
    logic [31:0]   root_d, root_q;
    logic [SW-1:0] side_q;

    always_comb begin : step
      logic [34:0] rem;
      logic [34:0] t;
      n_d    = n_s[g];
      rem    = {1'b0, rem_s[g]};
      root_d = root_s[g];
      t      = '0;
      for (int j = 0; j < PER; j++) begin
        if (g * PER + j < srpd_pkg::SQRT_STEPS) begin
          rem = {rem[32:0], n_d[63:62]};
          t   = {1'b0, root_d, 2'b01};
          if (rem >= t) begin
            rem    = rem - t;
            root_d = {root_d[30:0], 1'b1};
          end else begin
            root_d = {root_d[30:0], 1'b0};
          end
          n_d = {n_d[61:0], 2'b00};
        end
      end
      rem_d = rem[33:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q    <= n_d;
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= side_s[g];
      end
    end

    assign n_s[g+1]    = n_q;
    assign rem_s[g+1]  = rem_q;
    assign root_s[g+1] = root_q;
    assign side_s[g+1] = side_q;
  end

  assign root_o = root_s[STG];
  assign side_o = side_s[STG];

endmodule

@@ rtl/srpd_udiv.sv @@
// ----------------------------------------------------------------------------
// srpd_udiv: pipelined restoring divider
// Divides {rem0, lo} by den into QW quotient bits, two bits per stage; the
// caller guarantees rem0 < den for the quotient to be exact.
// ----------------------------------------------------------------------------
module srpd_udiv #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem0_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned STG = srpd_pkg::DIV_STAGES;
  localparam int unsigned PER = srpd_pkg::DIV_PER_STAGE;

  logic [DW-1:0] rem_s  [STG+1];
  logic [QW-1:0] lo_s   [STG+1];
  logic [QW-1:0] q_s    [STG+1];
  logic [DW-1:0] den_s  [STG+1];
  logic [SW-1:0] side_s [STG+1];

  assign rem_s[0]  = rem0_i;
  assign lo_s[0]   = lo_i;
  assign q_s[0]    = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;

  for (genvar g = 0; g < STG; g++) begin : g_stage
    logic [DW-1:0] rem_d, rem_q;
    logic [QW-1:0] lo_d, lo_q;
    logic [QW-1:0] q_d, q_q;
    logic [DW-1:0] den_q;
    logic [SW-1:0] side_q;

    always_comb begin : step
      logic [DW:0] t;
      rem_d = rem_s[g];
      lo_d  = lo_s[g];
      q_d   = q_s[g];
      t     = '0;
      for (int j = 0; j < PER; j++) begin
        if (g * PER + j < srpd_pkg::DIV_STEPS) begin
          t = {rem_d, lo_d[QW-1]};
          if (t >= {1'b0, den_s[g]}) begin
            t   = t - {1'b0, den_s[g]};
            q_d = {q_d[QW-2:0], 1'b1};
          end else begin
            q_d = {q_d[QW-2:0], 1'b0};
          end
          rem_d = t[DW-1:0];
          lo_d  = {lo_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        lo_q   <= lo_d;
        q_q    <= q_d;
        den_q  <= den_s[g];
        side_q <= side_s[g];
      end
    end

    assign rem_s[g+1]  = rem_q;
    assign lo_s[g+1]   = lo_q;
    assign q_s[g+1]    = q_q;
    assign den_s[g+1]  = den_q;
    assign side_s[g+1] = side_q;
  end

  assign q_o    = q_s[STG];
  assign side_o = side_s[STG];

endmodule

@@ rtl/srpd_cell.sv @@
// ----------------------------------------------------------------------------
// srpd_cell: weight pipeline for one falloff
// Distance to the falloff center, square root, falloff fraction and
// softness divide, giving a clamped Q1.16 weight.
// ----------------------------------------------------------------------------
module srpd_cell (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  srpd_pkg::entry_t     entry_i,
  input  logic                 active_i,
  input  logic [31:0]          brush_x_i,
  input  logic [31:0]          brush_y_i,
  input  logic [31:0]          px_i,
  input  logic [31:0]          py_i,
  output logic [16:0]          weight_o
);

  // stage 1: offsets and range check against the radius
  logic [33:0] dx, dy, ndx, ndy;
  logic [32:0] ax, ay;
  logic        kill1;

  assign dx  = {{2{brush_x_i[31]}}, brush_x_i} + {{2{entry_i.x[31]}}, entry_i.x}
             - {{2{px_i[31]}}, px_i};
  assign dy  = {{2{brush_y_i[31]}}, brush_y_i} + {{2{entry_i.y[31]}}, entry_i.y}
             - {{2{py_i[31]}}, py_i};
  assign ndx = 34'd0 - dx;
  assign ndy = 34'd0 - dy;
  assign ax  = dx[33] ? ndx[32:0] : dx[32:0];
  assign ay  = dy[33] ? ndy[32:0] : dy[32:0];
  assign kill1 = !active_i || (ax >= {1'b0, entry_i.r}) || (ay >= {1'b0, entry_i.r});

  logic [31:0] ax1_q, ay1_q, r1_q;
  logic [16:0] s1_q;
  logic        k1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= ax[31:0];
      ay1_q <= ay[31:0];
      r1_q  <= entry_i.r;
      s1_q  <= entry_i.s;
      k1_q  <= kill1;
    end
  end

  // stage 2: squares
  logic [63:0] sx2_q, sy2_q;
  logic [31:0] r2_q;
  logic [16:0] s2_q;
  logic        k2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx2_q <= {32'd0, ax1_q} * {32'd0, ax1_q};
      sy2_q <= {32'd0, ay1_q} * {32'd0, ay1_q};
      r2_q  <= r1_q;
      s2_q  <= s1_q;
      k2_q  <= k1_q;
    end
  end

  // stage 3: sum of squares, an overflow past 64 bits means no influence
  logic [64:0]         ssum;
  logic [63:0]         n3_q;
  srpd_pkg::sq_side_t  side3_q;

  assign ssum = {1'b0, sx2_q} + {1'b0, sy2_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n3_q         <= ssum[63:0];
      side3_q.r    <= r2_q;
      side3_q.s    <= s2_q;
      side3_q.kill <= k2_q | ssum[64];
    end
  end

  logic [31:0]        sq_root;
  srpd_pkg::sq_side_t sq_side;

  srpd_isqrt #(
    .SW($bits(srpd_pkg::sq_side_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .n_i    (n3_q),
    .side_i (side3_q),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // r - d ahead of the falloff divide
  logic [31:0] rd4_q, r4_q;
  logic [16:0] s4_q;
  logic        k4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd4_q <= sq_side.r - sq_root;
      r4_q  <= sq_side.r;
      s4_q  <= sq_side.s;
      k4_q  <= sq_side.kill | (sq_root >= sq_side.r);
    end
  end

  // f = (r - d) * 65536 / r
  logic [16:0] frac;
  logic [17:0] div1_side;

  srpd_udiv #(
    .DW(32),
    .QW(17),
    .SW(18)
  ) u_div_frac (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rem0_i ({1'b0, rd4_q[31:1]}),
    .lo_i   ({rd4_q[0], 16'd0}),
    .den_i  (r4_q),
    .side_i ({s4_q, k4_q}),
    .q_o    (frac),
    .side_o (div1_side)
  );

  // w = f * 65536 / s clamps to 1.0 exactly when f * 65536 >= 65537 * s
  logic [16:0] f5_q, s5_q;
  logic        zero5_q, clamp5_q;
  logic [33:0] lhs5, rhs5;

  assign lhs5 = {1'b0, frac, 16'd0};
  assign rhs5 = {1'b0, div1_side[17:1], 16'd0} + {17'd0, div1_side[17:1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f5_q     <= frac;
      s5_q     <= div1_side[17:1];
      zero5_q  <= div1_side[0] | (frac == 17'd0);
      clamp5_q <= lhs5 >= rhs5;
    end
  end

  logic [16:0] wq;
  logic [1:0]  div2_side;

  srpd_udiv #(
    .DW(17),
    .QW(17),
    .SW(2)
  ) u_div_soft (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rem0_i ({1'b0, f5_q[16:1]}),
    .lo_i   ({f5_q[0], 16'd0}),
    .den_i  (s5_q),
    .side_i ({zero5_q, clamp5_q}),
    .q_o    (wq),
    .side_o (div2_side)
  );

  logic [16:0] w_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (div2_side[1]) begin
        w_q <= '0;
      end else if (div2_side[0]) begin
        w_q <= srpd_pkg::ONE_Q16;
      end else begin
        w_q <= wq;
      end
    end
  end

  assign weight_o = w_q;

endmodule

@@ rtl/srpd_wsum.sv @@
// ----------------------------------------------------------------------------
// srpd_wsum: registered adder tree
// Sums the per-falloff weights, one register level per tree level.
// ----------------------------------------------------------------------------
module srpd_wsum #(
  parameter int unsigned N = 16
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] w_i [N],
  output logic [16 + ((N > 1) ? $clog2(N) : 0):0] sum_o
);

  localparam int unsigned L    = (N > 1) ? $clog2(N) : 0;
  localparam int unsigned P    = 1 << L;
  localparam int unsigned SUMW = 17 + L;

  if (L == 0) begin : g_single
    assign sum_o = SUMW'(w_i[0]);
  end else begin : g_tree
    logic [SUMW-1:0] leaf   [P];
    logic [SUMW-1:0] node_s [1:P-1];

    for (genvar i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_used
        assign leaf[i] = SUMW'(w_i[i]);
      end else begin : g_pad
        assign leaf[i] = '0;
      end
    end

    // heap order: node k sums nodes 2k and 2k+1, leaves sit at P..2P-1
    for (genvar k = 1; k < P; k++) begin : g_node
      logic [SUMW-1:0] a, b, node_q;
      if (2 * k >= P) begin : g_from_leaf
        assign a = leaf[2*k - P];
        assign b = leaf[2*k + 1 - P];
      end else begin : g_from_node
        assign a = node_s[2*k];
        assign b = node_s[2*k + 1];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q <= a + b;
        end
      end
      assign node_s[k] = node_q;
    end

    assign sum_o = node_s[1];
  end

endmodule

@@ rtl/soft_radial_point_displace.sv @@
// ----------------------------------------------------------------------------
// soft_radial_point_displace: soft radial falloff point displacement
// Keeps up to MAX_FALLOFFS circular falloffs around the brush and moves each
// point by its displacement scaled with the summed falloff weight. The block
// takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order, after the weight pipelines, the
// adder tree, a multiply register and the output register. Every falloff
// has its own weight pipeline; its depth is set by the 32-step square root
// and the two 17-step restoring divides, two steps a register stage, and
// the adder tree adds one level per doubling of the table. The table is
// taken at the cycle a word enters, so a move sees every append and clear
// that was taken before it. A stall on the output holds the whole pipeline.
// ----------------------------------------------------------------------------
module soft_radial_point_displace #(
  parameter int unsigned MAX_FALLOFFS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] x_in_i,
  input  logic signed [31:0] y_in_i,
  input  logic [31:0]        radius_in_i,
  input  logic [16:0]        softness_in_i,
  input  logic signed [31:0] move_dx_i,
  input  logic signed [31:0] move_dy_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic [16:0]        weight_o,
  output logic               table_full_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_FALLOFFS + 1);
  localparam int unsigned TREE_L = (MAX_FALLOFFS > 1) ? $clog2(MAX_FALLOFFS) : 0;
  localparam int unsigned SUM_W  = 17 + TREE_L;
  localparam int unsigned DLY    = srpd_pkg::CELL_LAT + TREE_L;

  // configuration registers
  logic [31:0] brush_x_q, brush_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_x_q <= '0;
      brush_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srpd_pkg::CFG_BRUSH_X: brush_x_q <= cfg_data_i;
        srpd_pkg::CFG_BRUSH_Y: brush_y_q <= cfg_data_i;
        default:               brush_x_q <= brush_x_q;
      endcase
    end
  end

  // handshake: the pipeline moves unless a finished word is held
  logic en, acc, out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  logic is_append, is_move, is_clear, full_now;
  logic [CNT_W-1:0] count_d, count_q;

  assign is_append = req_type_i == srpd_pkg::REQ_APPEND;
  assign is_move   = req_type_i == srpd_pkg::REQ_MOVE;
  assign is_clear  = req_type_i == srpd_pkg::REQ_CLEAR;
  assign full_now  = count_q == CNT_W'(MAX_FALLOFFS);

  always_comb begin
    count_d = count_q;
    if (acc && is_append && !full_now) begin
      count_d = count_q + CNT_W'(1);
    end else if (acc && is_clear) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // falloff table and one weight pipeline per entry
  srpd_pkg::entry_t entry_s [MAX_FALLOFFS];
  logic [16:0]      w_s     [MAX_FALLOFFS];

  for (genvar i = 0; i < MAX_FALLOFFS; i++) begin : g_falloff
    srpd_pkg::entry_t entry_q;

    always_ff @(posedge clk_i) begin
      if (acc && is_append && count_q == CNT_W'(i)) begin
        entry_q.x <= x_in_i;
        entry_q.y <= y_in_i;
        entry_q.r <= radius_in_i;
        entry_q.s <= softness_in_i;
      end
    end

    assign entry_s[i] = entry_q;

    srpd_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (en),
      .entry_i   (entry_s[i]),
      .active_i  (CNT_W'(i) < count_q),
      .brush_x_i (brush_x_q),
      .brush_y_i (brush_y_q),
      .px_i      (x_in_i),
      .py_i      (y_in_i),
      .weight_o  (w_s[i])
    );
  end

  logic [SUM_W-1:0] wsum;

  srpd_wsum #(
    .N(MAX_FALLOFFS)
  ) u_wsum (
    .clk_i (clk_i),
    .en_i  (en),
    .w_i   (w_s),
    .sum_o (wsum)
  );

  // word delay line alongside the weight pipelines
  srpd_pkg::pay_t pay_s [DLY+1];
  logic           v_s   [DLY+1];

  assign pay_s[0].move = is_move;
  assign pay_s[0].full = is_append && full_now;
  assign pay_s[0].px   = x_in_i;
  assign pay_s[0].py   = y_in_i;
  assign pay_s[0].dx   = move_dx_i;
  assign pay_s[0].dy   = move_dy_i;
  assign v_s[0]        = acc;

  for (genvar g = 0; g < DLY; g++) begin : g_dly
    srpd_pkg::pay_t pay_q;
    logic           v_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= v_s[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pay_q <= pay_s[g];
      end
    end

    assign pay_s[g+1] = pay_q;
    assign v_s[g+1]   = v_q;
  end

  // saturate the sum and scale the displacement
  srpd_pkg::pay_t pay_t_l;
  logic [16:0]    wsat;
  logic [31:0]    absx, absy;

  assign pay_t_l = pay_s[DLY];
  assign wsat    = (wsum > SUM_W'(srpd_pkg::ONE_Q16)) ? srpd_pkg::ONE_Q16 : wsum[16:0];
  assign absx    = pay_t_l.dx[31] ? (32'd0 - pay_t_l.dx) : pay_t_l.dx;
  assign absy    = pay_t_l.dy[31] ? (32'd0 - pay_t_l.dy) : pay_t_l.dy;

  logic        m_v_q, m_move_q, m_full_q, m_negx_q, m_negy_q;
  logic [16:0] m_w_q;
  logic [48:0] m_mx_q, m_my_q;
  logic [31:0] m_px_q, m_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= v_s[DLY];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_move_q <= pay_t_l.move;
      m_full_q <= pay_t_l.full;
      m_negx_q <= pay_t_l.dx[31];
      m_negy_q <= pay_t_l.dy[31];
      m_w_q    <= wsat;
      m_mx_q   <= {17'd0, absx} * {32'd0, wsat};
      m_my_q   <= {17'd0, absy} * {32'd0, wsat};
      m_px_q   <= pay_t_l.px;
      m_py_q   <= pay_t_l.py;
    end
  end

  // output register
  logic [31:0] new_x_q, new_y_q;
  logic [16:0] weight_q;
  logic        table_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      table_full_q <= m_full_q;
      if (m_move_q) begin
        new_x_q  <= srpd_pkg::move_axis(m_px_q, m_negx_q, m_mx_q);
        new_y_q  <= srpd_pkg::move_axis(m_py_q, m_negy_q, m_my_q);
        weight_q <= m_w_q;
      end else begin
        new_x_q  <= '0;
        new_y_q  <= '0;
        weight_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_x_o      = new_x_q;
  assign new_y_o      = new_y_q;
  assign weight_o     = weight_q;
  assign table_full_o = table_full_q;

`ifndef ASSERT_OFF
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_append && !full_now) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("falloff count did not advance on append");

  a_full_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (new_x_o == '0 && new_y_o == '0 && weight_o == '0))
    else $error("rejected append carries a nonzero result");

  a_weight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weight_o <= srpd_pkg::ONE_Q16)
    else $error("weight above 1.0");
`endif

endmodule
